// ===== rtl/core/tst_pkg.sv =====
package tst_pkg;

  // Default table geometry.
  localparam int TOPICS_DEF   = 16;
  localparam int SUBS_DEF     = 8;

  // Operation codes of the mode field.
  localparam logic [1:0] MODE_SUB    = 2'd0;
  localparam logic [1:0] MODE_UNSUB  = 2'd1;
  localparam logic [1:0] MODE_PUB    = 2'd2;
  localparam logic [1:0] MODE_REMALL = 2'd3;

  // Status codes of a result.
  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_DUP        = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL = 3'd2;
  localparam logic [2:0] ST_LIST_FULL  = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

endpackage

// ===== rtl/core/tst_ram.sv =====
module tst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/topic_subscription_table.sv =====
// Publish/subscribe fan-out table. Raise start while busy is low to issue one
// transaction; busy stays high while it is worked and falls in the cycle that
// carries its final result. Results appear on the out_ ports, marked by
// out_valid, and the receiver cannot stall them, so it must take every strobed
// result. Each transaction is worked by a small sequencer around key, count and
// list RAMs, each with a registered read: a topic search reads and compares the
// key of each slot in use until one matches, a list walk reads and handles each
// entry in turn, and remove-all walks every list in use. No clearing pass.
module topic_subscription_table #(
  parameter int TOPICS         = tst_pkg::TOPICS_DEF,
  parameter int SUBS_PER_TOPIC = tst_pkg::SUBS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_client_id,
  input  logic [15:0] in_topic_hash,
  output logic       out_valid,
  output logic [7:0] out_subscriber_id,
  output logic       out_has_subscriber,
  output logic       out_last,
  output logic [2:0] out_status
);

  localparam int TW = (TOPICS > 1) ? $clog2(TOPICS) : 1;
  localparam int SW = (SUBS_PER_TOPIC > 1) ? $clog2(SUBS_PER_TOPIC) : 1;
  localparam int CW = $clog2(SUBS_PER_TOPIC + 1);
  localparam int UW = $clog2(TOPICS + 1);
  localparam int LD = TOPICS * SUBS_PER_TOPIC;
  localparam int LW = (LD > 1) ? $clog2(LD) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FRD   = 4'd1;  // key read issued
  localparam logic [3:0] S_FCMP  = 4'd2;  // compare key
  localparam logic [3:0] S_LRD   = 4'd3;  // list entry read issued
  localparam logic [3:0] S_LCMP  = 4'd4;  // handle list entry
  localparam logic [3:0] S_LEND  = 4'd5;  // list walk finished
  localparam logic [3:0] S_OUT   = 4'd6;  // single result
  localparam logic [3:0] S_CRD   = 4'd7;  // count read issued
  localparam logic [3:0] S_CGET  = 4'd8;  // count arrives

  logic [3:0]    state_r, state_nxt;
  logic [1:0]    mode_r;
  logic [7:0]    cid_r;
  logic [15:0]   hash_r;
  logic [UW-1:0] used_r, used_nxt;
  logic [UW-1:0] t_r, t_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic          any_r, any_nxt;
  logic [2:0]    st_r, st_nxt;
  logic          found_r, found_nxt;

  // Key, count and list stores.
  logic          key_we, cnt_we, lst_we;
  logic [TW-1:0] key_waddr, key_raddr, cnt_waddr, cnt_raddr;
  logic [15:0]   key_wdata, key_rdata;
  logic [CW-1:0] cnt_wdata, cnt_rdata;
  logic [LW-1:0] lst_waddr, lst_raddr;
  logic [7:0]    lst_wdata, lst_rdata;

  tst_ram #(.WIDTH(16), .DEPTH(TOPICS)) u_keys (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_rdata));
  tst_ram #(.WIDTH(CW), .DEPTH(TOPICS)) u_cnts (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata));
  tst_ram #(.WIDTH(8), .DEPTH(LD)) u_lists (
    .clk(clk), .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
    .raddr(lst_raddr), .rdata(lst_rdata));

  logic [TW-1:0] t_idx;
  logic [LW-1:0] base;
  assign t_idx = t_r[TW-1:0];
  assign base  = LW'(t_idx) * LW'(SUBS_PER_TOPIC);

  // Output register.
  logic       ov_r, ov_nxt, ohas_r, ohas_nxt, olast_r, olast_nxt;
  logic [7:0] oid_r, oid_nxt;
  logic [2:0] ost_r, ost_nxt;

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    t_nxt     = t_r;
    n_nxt     = n_r;
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    any_nxt   = any_r;
    st_nxt    = st_r;
    found_nxt = found_r;
    key_we = 1'b0; key_waddr = t_idx; key_wdata = hash_r; key_raddr = t_idx;
    cnt_we = 1'b0; cnt_waddr = t_idx; cnt_wdata = '0; cnt_raddr = t_idx;
    lst_we = 1'b0; lst_waddr = base + LW'(wr_r); lst_wdata = lst_rdata;
    lst_raddr = base + LW'(rd_r);
    ov_nxt = 1'b0; ohas_nxt = 1'b0; olast_nxt = 1'b0; oid_nxt = '0;
    ost_nxt = tst_pkg::ST_DONE;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          t_nxt   = '0;
          any_nxt = 1'b0;
          st_nxt  = tst_pkg::ST_DONE;
          if (used_r == '0) begin
            state_nxt = (in_mode == tst_pkg::MODE_REMALL) ? S_OUT : S_FCMP;
            found_nxt = 1'b0;
            state_nxt = S_LEND;
            t_nxt     = '0;
          end else begin
            state_nxt = (in_mode == tst_pkg::MODE_REMALL) ? S_CRD : S_FRD;
          end
        end
      end
      S_FRD: begin
        state_nxt = S_FCMP;
      end
      S_FCMP: begin
        if (key_rdata == hash_r) begin
          found_nxt = 1'b1;
          state_nxt = S_CRD;
        end else if (t_r + 1'b1 == used_r) begin
          found_nxt = 1'b0;
          state_nxt = S_LEND;
        end else begin
          t_nxt     = t_r + 1'b1;
          state_nxt = S_FRD;
        end
      end
      S_CRD: begin
        state_nxt = S_CGET;
      end
      S_CGET: begin
        n_nxt  = (cnt_rdata > CW'(SUBS_PER_TOPIC)) ? CW'(SUBS_PER_TOPIC) : cnt_rdata;
        rd_nxt = '0;
        wr_nxt = '0;
        found_nxt = 1'b1;
        state_nxt = (n_nxt == '0) ? S_LEND : S_LRD;
      end
      S_LRD: begin
        state_nxt = S_LCMP;
      end
      S_LCMP: begin
        // One list entry per visit: publish emits it, subscribe checks it,
        // removal compacts it.
        if (mode_r == tst_pkg::MODE_PUB) begin
          ov_nxt = 1'b1; ohas_nxt = 1'b1; oid_nxt = lst_rdata;
          olast_nxt = (rd_r + 1'b1 == n_r);
        end else if (mode_r == tst_pkg::MODE_SUB) begin
          if (lst_rdata == cid_r) st_nxt = tst_pkg::ST_DUP;
        end else if (lst_rdata != cid_r) begin
          lst_we = 1'b1;
          wr_nxt = wr_r + 1'b1;
        end
        rd_nxt = rd_r + 1'b1;
        if (rd_r + 1'b1 == n_r) begin
          state_nxt = (mode_r == tst_pkg::MODE_PUB) ? S_IDLE : S_LEND;
        end else begin
          state_nxt = S_LRD;
        end
      end
      S_LEND: begin
        state_nxt = S_OUT;
        if (mode_r == tst_pkg::MODE_SUB) begin
          if (found_r) begin
            if (st_r == tst_pkg::ST_DONE) begin
              if (n_r < CW'(SUBS_PER_TOPIC)) begin
                lst_we = 1'b1; lst_waddr = base + LW'(n_r); lst_wdata = cid_r;
                cnt_we = 1'b1; cnt_wdata = n_r + 1'b1;
              end else begin
                st_nxt = tst_pkg::ST_LIST_FULL;
              end
            end
          end else if (used_r < UW'(TOPICS)) begin
            t_nxt = used_r;
            key_we = 1'b1; key_waddr = used_r[TW-1:0];
            cnt_we = 1'b1; cnt_waddr = used_r[TW-1:0]; cnt_wdata = CW'(1);
            lst_we = 1'b1; lst_waddr = LW'(used_r[TW-1:0]) * LW'(SUBS_PER_TOPIC);
            lst_wdata = cid_r;
            used_nxt = used_r + 1'b1;
          end else begin
            st_nxt = tst_pkg::ST_TABLE_FULL;
          end
        end else if (mode_r == tst_pkg::MODE_PUB) begin
          st_nxt = found_r ? tst_pkg::ST_DONE : tst_pkg::ST_NOT_FOUND;
        end else if (mode_r == tst_pkg::MODE_UNSUB) begin
          if (found_r) begin
            cnt_we = 1'b1; cnt_wdata = wr_r;
          end
          st_nxt = (found_r && wr_r != n_r) ? tst_pkg::ST_DONE : tst_pkg::ST_NOT_FOUND;
        end else begin
          // Remove-all: close this slot, then move on to the next one.
          if (found_r) begin
            cnt_we = 1'b1; cnt_wdata = wr_r;
          end
          if (found_r && wr_r != n_r) any_nxt = 1'b1;
          if (found_r && t_r + 1'b1 < used_r) begin
            t_nxt = t_r + 1'b1;
            state_nxt = S_CRD;
          end else begin
            st_nxt = (any_nxt) ? tst_pkg::ST_DONE : tst_pkg::ST_NOT_FOUND;
          end
        end
      end
      S_OUT: begin
        ov_nxt = 1'b1; olast_nxt = 1'b1; ost_nxt = st_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      mode_r <= in_mode;
      cid_r  <= in_client_id;
      hash_r <= in_topic_hash;
    end
    t_r     <= t_nxt;
    n_r     <= n_nxt;
    rd_r    <= rd_nxt;
    wr_r    <= wr_nxt;
    any_r   <= any_nxt;
    st_r    <= st_nxt;
    found_r <= found_nxt;
    ohas_r  <= ohas_nxt;
    olast_r <= olast_nxt;
    oid_r   <= oid_nxt;
    ost_r   <= ost_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = ov_r;
  assign out_subscriber_id  = oid_r;
  assign out_has_subscriber = ohas_r;
  assign out_last           = olast_r;
  assign out_status         = ost_r;

  // The topic count never exceeds the table size.
  assert property (@(posedge clk) disable iff (!rst_n) used_r <= UW'(TOPICS))
    else $error("topic count overflow");
  // A transaction is only taken while idle, and then work starts.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && start) |=> busy)
    else $error("accepted transaction did not start");
  // A result without a subscriber always closes the transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_subscriber) |-> out_last)
    else $error("empty result not marked last");

endmodule
